// File: rtl/pngse_pkg.sv
// shared types, constants and functions of the png stored-deflate encoder
`timescale 1ns / 1ps
package pngse_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CRC_INIT  = 32'hffffffff;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [31:0] IHDR_LEN  = 32'd13;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454e44;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [7:0]  SAMPLE_BITS = 8'd8;
  localparam logic [7:0]  CTYPE_RGB = 8'd2;
  localparam logic [7:0]  CTYPE_RGBA = 8'd6;
  localparam logic [31:0] IDAT_FIXED = 32'd6;   // zlib header plus adler
  localparam logic [16:0] BLOCK_HDR  = 17'd5;   // per-row stored block header

  // configuration as the datapath sees it
  typedef struct packed {
    logic [13:0] w_eff;
    logic [14:0] h_eff;
    logic        alpha;
    logic [15:0] row_len;
    logic [15:0] pitch;
    logic [31:0] idat_len;
  } cfg_t;

  // one classified image byte
  typedef struct packed {
    logic [7:0] data;
    logic       first_file;
    logic       first_row;
    logic       last_row;
    logic       last_img;
  } item_t;

  function automatic logic [31:0] crc_nib(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'h0: v = 32'h00000000;
      4'h1: v = 32'h1db71064;
      4'h2: v = 32'h3b6e20c8;
      4'h3: v = 32'h26d930ac;
      4'h4: v = 32'h76dc4190;
      4'h5: v = 32'h6b6b51f4;
      4'h6: v = 32'h4db26158;
      4'h7: v = 32'h5005713c;
      4'h8: v = 32'hedb88320;
      4'h9: v = 32'hf00f9344;
      4'ha: v = 32'hd6d6a3e8;
      4'hb: v = 32'hcb61b38c;
      4'hc: v = 32'h9b64c2b0;
      4'hd: v = 32'h86d3d2d4;
      4'he: v = 32'ha00ae278;
      default: v = 32'hbdbdf21c;
    endcase
    return v;
  endfunction

  // two nibble lookups per byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    c = (c >> 4) ^ crc_nib(c[3:0]);
    c = (c >> 4) ^ crc_nib(c[3:0]);
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4e;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0d;
      3'd5: v = 8'h0a;
      3'd6: v = 8'h1a;
      default: v = 8'h0a;
    endcase
    return v;
  endfunction

  // big endian byte i of a word
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
    logic [4:0] sh;
    sh = {~i, 3'b000};
    return 8'(v >> sh);
  endfunction

endpackage

// File: rtl/pngse_cfg.sv
// configuration registers and values derived from them
`timescale 1ns / 1ps
module pngse_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pngse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pngse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pngse_pkg::cfg_t                    cfg
);
  import pngse_pkg::*;

  logic [13:0] width_reg;
  logic [14:0] height_reg;
  logic        alpha_reg;
  logic [15:0] pitch;
  logic [31:0] idat_len;
  logic [13:0] w_eff;
  logic [14:0] h_eff;
  logic [15:0] row_len;
  logic [16:0] pitch5;
  logic [31:0] prod;

  assign w_eff   = (width_reg == '0) ? 14'd1 : width_reg;
  assign h_eff   = (height_reg == '0) ? 15'd1 : height_reg;
  assign row_len = alpha_reg ? {w_eff, 2'b00} : ({1'b0, w_eff, 1'b0} + {2'b00, w_eff});
  assign pitch5  = {1'b0, pitch} + BLOCK_HDR;
  assign prod    = {17'd0, h_eff} * {15'd0, pitch5};

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 14'd1;
      height_reg <= 15'd1;
      alpha_reg  <= 1'b0;
      pitch      <= 16'd4;
      idat_len   <= 32'd15;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WIDTH:  width_reg  <= cfg_data[13:0];
          CFG_HEIGHT: height_reg <= cfg_data[14:0];
          CFG_ALPHA:  alpha_reg  <= cfg_data[0];
          default: ;
        endcase
      end
      pitch    <= row_len + 16'd1;
      idat_len <= prod + IDAT_FIXED;
    end
  end

  assign cfg.w_eff    = w_eff;
  assign cfg.h_eff    = h_eff;
  assign cfg.alpha    = alpha_reg;
  assign cfg.row_len  = row_len;
  assign cfg.pitch    = pitch;
  assign cfg.idat_len = idat_len;

endmodule

// File: rtl/pngse_front.sv
// input side: tracks position in the image and classifies each byte
`timescale 1ns / 1ps
module pngse_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          data_byte,
  input  logic                q_full,
  input  pngse_pkg::cfg_t     cfg,
  output logic                q_push,
  output pngse_pkg::item_t    q_item
);
  import pngse_pkg::*;

  logic        header_done;
  logic [14:0] row_index;
  logic [15:0] byte_in_row;
  logic [14:0] row_index_next;
  logic [15:0] byte_in_row_next;
  logic [16:0] bir1;
  logic [15:0] row1;
  logic        row_end;
  logic        last_row;
  logic        last_img;

  assign q_push   = push && !q_full;
  assign bir1     = {1'b0, byte_in_row} + 17'd1;
  assign row1     = {1'b0, row_index} + 16'd1;
  assign row_end  = bir1 >= {1'b0, cfg.row_len};
  assign last_row = row1 >= {1'b0, cfg.h_eff};
  assign last_img = row_end && last_row;

  assign q_item.data       = data_byte;
  assign q_item.first_file = !header_done;
  assign q_item.first_row  = byte_in_row == '0;
  assign q_item.last_row   = last_row;
  assign q_item.last_img   = last_img;

  always_comb begin
    byte_in_row_next = row_end ? 16'd0 : bir1[15:0];
    row_index_next   = (row_end && !last_row) ? row1[14:0] : row_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_done <= 1'b0;
      row_index   <= '0;
      byte_in_row <= '0;
    end else if (q_push) begin
      if (last_img) begin
        header_done <= 1'b0;
        row_index   <= '0;
        byte_in_row <= '0;
      end else begin
        header_done <= 1'b1;
        row_index   <= row_index_next;
        byte_in_row <= byte_in_row_next;
      end
    end
  end

endmodule

// File: rtl/pngse_queue.sv
// short queue of classified bytes between front and back
`timescale 1ns / 1ps
module pngse_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  pngse_pkg::item_t    wr_item,
  output logic                full,
  input  logic                rd,
  output pngse_pkg::item_t    rd_item,
  output logic                empty
);
  import pngse_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= QPTR_W'((QPTR_W + 1)'(wptr) + 1'b1);
      end
      if (rd) begin
        rptr <= QPTR_W'((QPTR_W + 1)'(rptr) + 1'b1);
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/pngse_back.sv
// output side: byte sequencer with crc, adler and the output register
`timescale 1ns / 1ps
module pngse_back (
  input  logic                clk,
  input  logic                rst,
  input  pngse_pkg::cfg_t     cfg,
  input  pngse_pkg::item_t    q_item,
  input  logic                q_empty,
  output logic                q_pop,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                stream_end,
  output logic                empty,
  input  logic                pop
);
  import pngse_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SIG, PH_HLEN, PH_HTYPE, PH_HDATA, PH_HCRC, PH_ILEN, PH_ITYPE,
    PH_ZHDR, PH_ROWHDR, PH_FILTER, PH_DATA, PH_ADLER, PH_ICRC, PH_ELEN,
    PH_ETYPE, PH_ECRC
  } phase_t;

  typedef enum logic [1:0] {MODE_RAW, MODE_CRC, MODE_CRC_INIT, MODE_ADLER} mode_t;

  phase_t      phase;
  phase_t      ph_after;
  phase_t      ph_start;
  mode_t       mode;
  item_t       cur;
  logic [3:0]  k;
  logic [3:0]  last_k;
  logic [31:0] crc_reg;
  logic [15:0] adler_low;
  logic [15:0] adler_high;
  logic        out_valid;
  logic [7:0]  byte_val;
  logic        emit;
  logic        adv;
  logic        item_done;
  logic        final_byte;
  logic        take;
  logic [31:0] crc_next;
  logic [16:0] lo_sum;
  logic [15:0] lo_next;
  logic [16:0] hi_sum;
  logic [15:0] hi_next;

  assign emit       = phase != PH_IDLE;
  assign adv        = !out_valid || pop;
  assign final_byte = (phase == PH_ECRC) && (k == 4'd3);
  assign item_done  = ((phase == PH_DATA) && !cur.last_img) || final_byte;
  assign take       = !q_empty && ((phase == PH_IDLE) || (emit && adv && item_done));
  assign q_pop      = take;
  assign empty      = !out_valid;

  always_comb begin
    if (q_item.first_file) begin
      ph_start = PH_SIG;
    end else if (q_item.first_row) begin
      ph_start = PH_ROWHDR;
    end else begin
      ph_start = PH_DATA;
    end
  end

  // byte value, checksum mode, phase length and successor
  always_comb begin
    byte_val = 8'd0;
    mode     = MODE_RAW;
    last_k   = 4'd3;
    ph_after = PH_IDLE;
    unique case (phase)
      PH_SIG: begin
        byte_val = sig_byte(k[2:0]);
        last_k   = 4'd7;
        ph_after = PH_HLEN;
      end
      PH_HLEN: begin
        byte_val = be_byte(IHDR_LEN, k[1:0]);
        ph_after = PH_HTYPE;
      end
      PH_HTYPE: begin
        byte_val = be_byte(TYPE_IHDR, k[1:0]);
        mode     = (k == 4'd0) ? MODE_CRC_INIT : MODE_CRC;
        ph_after = PH_HDATA;
      end
      PH_HDATA: begin
        mode     = MODE_CRC;
        last_k   = 4'd12;
        ph_after = PH_HCRC;
        case (k)
          4'd0, 4'd1, 4'd2, 4'd3: byte_val = be_byte({18'd0, cfg.w_eff}, k[1:0]);
          4'd4, 4'd5, 4'd6, 4'd7: byte_val = be_byte({17'd0, cfg.h_eff}, k[1:0]);
          4'd8:    byte_val = SAMPLE_BITS;
          4'd9:    byte_val = cfg.alpha ? CTYPE_RGBA : CTYPE_RGB;
          default: byte_val = 8'd0;
        endcase
      end
      PH_HCRC: begin
        byte_val = be_byte(~crc_reg, k[1:0]);
        ph_after = PH_ILEN;
      end
      PH_ILEN: begin
        byte_val = be_byte(cfg.idat_len, k[1:0]);
        ph_after = PH_ITYPE;
      end
      PH_ITYPE: begin
        byte_val = be_byte(TYPE_IDAT, k[1:0]);
        mode     = (k == 4'd0) ? MODE_CRC_INIT : MODE_CRC;
        ph_after = PH_ZHDR;
      end
      PH_ZHDR: begin
        byte_val = (k == 4'd0) ? ZLIB_CMF : ZLIB_FLG;
        mode     = MODE_CRC;
        last_k   = 4'd1;
        ph_after = cur.first_row ? PH_ROWHDR : PH_DATA;
      end
      PH_ROWHDR: begin
        mode     = MODE_CRC;
        last_k   = 4'd4;
        ph_after = PH_FILTER;
        case (k)
          4'd0:    byte_val = {7'd0, cur.last_row};
          4'd1:    byte_val = cfg.pitch[7:0];
          4'd2:    byte_val = cfg.pitch[15:8];
          4'd3:    byte_val = ~cfg.pitch[7:0];
          default: byte_val = ~cfg.pitch[15:8];
        endcase
      end
      PH_FILTER: begin
        byte_val = 8'd0;
        mode     = MODE_ADLER;
        last_k   = 4'd0;
        ph_after = PH_DATA;
      end
      PH_DATA: begin
        byte_val = cur.data;
        mode     = MODE_ADLER;
        last_k   = 4'd0;
        ph_after = PH_ADLER;
      end
      PH_ADLER: begin
        byte_val = be_byte({adler_high, adler_low}, k[1:0]);
        mode     = MODE_CRC;
        ph_after = PH_ICRC;
      end
      PH_ICRC: begin
        byte_val = be_byte(~crc_reg, k[1:0]);
        ph_after = PH_ELEN;
      end
      PH_ELEN: begin
        byte_val = 8'd0;
        ph_after = PH_ETYPE;
      end
      PH_ETYPE: begin
        byte_val = be_byte(TYPE_IEND, k[1:0]);
        mode     = (k == 4'd0) ? MODE_CRC_INIT : MODE_CRC;
        ph_after = PH_ECRC;
      end
      PH_ECRC: begin
        byte_val = be_byte(~crc_reg, k[1:0]);
        ph_after = PH_IDLE;
      end
      default: begin
        byte_val = 8'd0;
      end
    endcase
  end

  // running checksums
  always_comb begin
    crc_next = crc_byte((mode == MODE_CRC_INIT) ? CRC_INIT : crc_reg, byte_val);
    lo_sum   = {1'b0, adler_low} + {9'd0, byte_val};
    lo_next  = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    hi_sum   = {1'b0, adler_high} + {1'b0, lo_next};
    hi_next  = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      k          <= '0;
      out_valid  <= 1'b0;
      crc_reg    <= CRC_INIT;
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
    end else begin
      if (adv) begin
        out_valid <= emit;
      end
      if (take) begin
        phase <= ph_start;
        k     <= '0;
      end else if (emit && adv) begin
        if (item_done) begin
          phase <= PH_IDLE;
        end else if (k == last_k) begin
          phase <= ph_after;
          k     <= '0;
        end else begin
          k <= k + 4'd1;
        end
      end
      if (emit && adv) begin
        if (mode != MODE_RAW) begin
          crc_reg <= crc_next;
        end
        if (final_byte) begin
          adler_low  <= 16'd1;
          adler_high <= 16'd0;
        end else if (mode == MODE_ADLER) begin
          adler_low  <= lo_next;
          adler_high <= hi_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_item;
    end
    if (emit && adv) begin
      out_byte   <= byte_val;
      run_last   <= item_done;
      stream_end <= final_byte;
    end
  end

endmodule

// File: rtl/png_stored_deflate_encoder.sv
// top level of the png encoder with stored deflate blocks
`timescale 1ns / 1ps
//
// channel   direction  handshake                 payload
// input     in         push / full               data_byte
// result    out        empty / pop               out_byte, run_last, stream_end
// config    in         cfg_write (no wait)       cfg_index, cfg_data
//
// in steady state the back sequencer emits one byte per cycle while the output
// register is free or being popped, and picks up the next queued byte in the same cycle
// file start adds signature, ihdr and idat/zlib headers; row start adds block
// header and filter byte; image end adds adler, idat crc and the iend chunk
// a 4-entry queue splits the front from the back, so push keeps going while
// the output register waits on pop; full rises only when the queue is full
// rst is synchronous; registers come back as width 1, height 1, rgb
module png_stored_deflate_encoder (
  input  logic                               clk,
  input  logic                               rst,
  // input transactions
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         data_byte,
  // result transactions
  output logic                               empty,
  input  logic                               pop,
  output logic [7:0]                         out_byte,
  output logic                               run_last,
  output logic                               stream_end,
  // configuration writes
  input  logic                               cfg_write,
  input  logic [pngse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pngse_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pngse_pkg::*;

  cfg_t  cfg;
  item_t fq_item;    // front to queue
  item_t qb_item;    // queue to back
  logic  fq_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  // registers plus derived row length, block pitch and idat length
  pngse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // tags each byte as first of file, first of row, in last row, last of image
  pngse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .q_full    (q_full),
    .cfg       (cfg),
    .q_push    (fq_push),
    .q_item    (fq_item)
  );

  assign full = q_full;

  pngse_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fq_push),
    .wr_item (fq_item),
    .full    (q_full),
    .rd      (q_pop),
    .rd_item (qb_item),
    .empty   (q_empty)
  );

  // expands each tagged byte into file bytes, keeps crc-32 and adler-32
  pngse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_item     (qb_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
